/* hw/rtl/owsm_pkg.sv */
// Shared constants for the opacity-weighted splat merge block.
package owsm_pkg;

    // Field formats
    localparam int COMP_W  = 32;                // Q16.16 component
    localparam int ALPHA_W = 16;                // Q1.15 opacity
    localparam int NCOMP   = 9;                 // position, color, scale
    localparam int MUL_W   = COMP_W + ALPHA_W;  // exact component * alpha

    // Sequencer counter widths
    localparam int IDX_W  = $clog2(NCOMP + 2);  // accumulate pass, NCOMP + 2 slots
    localparam int CI_W   = $clog2(NCOMP);      // component index
    localparam int STEP_W = $clog2(COMP_W);     // quotient bit counter

    // Fixed-point unity values
    localparam logic [16:0]        ONE_Q16 = 17'h10000;
    localparam logic [ALPHA_W-1:0] ONE_Q15 = 16'h8000;

    // Default group limit
    localparam int MAX_GROUP_DEF = 64;

endpackage

/* hw/rtl/opacity_weighted_splat_merge.sv */
// Opacity-weighted splat merge: one shared multiplier and one divider step under a sequencer.
//
// Splats arrive one transaction at a time on the input channel; each is held
// while the single 33x18 multiplier forms the nine component * alpha
// products and the transparency update, one per cycle, with a register between
// multiply and accumulate. A splat marked last then starts the group merge:
// nine restoring divisions of the weighted sums by the total opacity run one
// after another on a shared subtract/compare step. The merged splat sits in an
// output register; the next splat is accepted while it waits to be taken, and
// only the end of the following group waits on it. Splats beyond MAX_GROUP in
// a group are dropped and reported through group_overflow.
module opacity_weighted_splat_merge
    import owsm_pkg::*;
#(
    parameter int MAX_GROUP = MAX_GROUP_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    // Input channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COMP_W-1:0]  pos_x,
    input  logic signed [COMP_W-1:0]  pos_y,
    input  logic signed [COMP_W-1:0]  pos_z,
    input  logic signed [COMP_W-1:0]  color_r,
    input  logic signed [COMP_W-1:0]  color_g,
    input  logic signed [COMP_W-1:0]  color_b,
    input  logic signed [COMP_W-1:0]  size_x,
    input  logic signed [COMP_W-1:0]  size_y,
    input  logic signed [COMP_W-1:0]  size_z,
    input  logic        [ALPHA_W-1:0] alpha,
    input  logic                      last_in_group,

    // Output channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [COMP_W-1:0]  merged_x,
    output logic signed [COMP_W-1:0]  merged_y,
    output logic signed [COMP_W-1:0]  merged_z,
    output logic signed [COMP_W-1:0]  merged_r,
    output logic signed [COMP_W-1:0]  merged_g,
    output logic signed [COMP_W-1:0]  merged_b,
    output logic signed [COMP_W-1:0]  merged_sx,
    output logic signed [COMP_W-1:0]  merged_sy,
    output logic signed [COMP_W-1:0]  merged_sz,
    output logic        [ALPHA_W-1:0] merged_alpha,
    output logic                      group_overflow
);

    // Widths that follow from the group limit
    localparam int CNT_W = $clog2(MAX_GROUP + 1);
    localparam int TOT_W = ALPHA_W + CNT_W;
    localparam int SUM_W = MUL_W + CNT_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACC   = 3'd1;
    localparam logic [2:0] S_DLOAD = 3'd2;
    localparam logic [2:0] S_DSTEP = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]               state_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [CI_W-1:0]          div_idx_reg;
    logic [STEP_W-1:0]        step_reg;

    // Held input transaction
    logic [COMP_W-1:0]        comp_reg [NCOMP];
    logic [ALPHA_W-1:0]       alpha_reg;
    logic                     last_reg;

    // Group accumulators
    logic [SUM_W-1:0]         sums_reg [NCOMP];
    logic [TOT_W-1:0]         total_reg;
    logic [16:0]              prod_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     ovf_reg;

    // Shared multiplier result
    logic signed [50:0]       mul_reg;

    // Divider state
    logic [TOT_W-1:0]         rem_reg;
    logic [COMP_W-1:0]        qsh_reg;
    logic                     neg_reg;
    logic [COMP_W-1:0]        quot_reg [NCOMP];

    // Output registers
    logic                     out_valid_reg;
    logic [COMP_W-1:0]        merged_reg [NCOMP];
    logic [ALPHA_W-1:0]       merged_alpha_reg;
    logic                     group_overflow_reg;

    // Combinational helpers
    logic                     in_fire;
    logic                     out_free;
    logic                     grp_full;
    logic                     mul_comp;
    logic [CI_W-1:0]          mul_sel;
    logic [CI_W-1:0]          acc_idx;
    logic [ALPHA_W-1:0]       alpha_clamp;
    logic [16:0]              transp;
    logic signed [32:0]       mul_a;
    logic signed [17:0]       mul_b;
    logic signed [50:0]       mul_next;
    logic [SUM_W-1:0]         mul_ext;
    logic [SUM_W-1:0]         sum_rd;
    logic [SUM_W-1:0]         sum_mag;
    logic [TOT_W-1:0]         div_d;
    logic [TOT_W:0]           rem_sh;
    logic                     rem_ge;
    logic [TOT_W-1:0]         rem_next;
    logic [COMP_W-1:0]        qsh_next;
    logic [COMP_W-1:0]        q_signed;
    logic [16:0]              alpha_diff;

    // Handshake
    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign grp_full = (cnt_reg >= CNT_W'(MAX_GROUP));

    // Multiplier operand select: components first, transparency last
    assign mul_comp    = (idx_reg < IDX_W'(NCOMP));
    assign mul_sel     = mul_comp ? idx_reg[CI_W-1:0] : '0;
    assign acc_idx     = idx_reg[CI_W-1:0] - CI_W'(1);
    assign alpha_clamp = (alpha_reg > ONE_Q15) ? ONE_Q15 : alpha_reg;
    assign transp      = ONE_Q16 - {alpha_clamp, 1'b0};

    always_comb
    begin
        if (mul_comp)
        begin
            mul_a = $signed({comp_reg[mul_sel][COMP_W-1], comp_reg[mul_sel]});
            mul_b = $signed({2'b00, alpha_reg});
        end
        else
        begin
            mul_a = $signed({16'd0, prod_reg});
            mul_b = $signed({1'b0, transp});
        end
    end

    assign mul_next = mul_a * mul_b;
    assign mul_ext  = {{(SUM_W - MUL_W){mul_reg[MUL_W-1]}}, mul_reg[MUL_W-1:0]};

    // Divider step: magnitude long division, 32 quotient bits
    assign sum_rd   = sums_reg[div_idx_reg];
    assign sum_mag  = sum_rd[SUM_W-1] ? (SUM_W'(0) - sum_rd) : sum_rd;
    assign div_d    = (total_reg == '0) ? TOT_W'(1) : total_reg;
    assign rem_sh   = {rem_reg, qsh_reg[COMP_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, div_d});
    assign rem_next = rem_ge ? TOT_W'(rem_sh - {1'b0, div_d}) : rem_sh[TOT_W-1:0];
    assign qsh_next = {qsh_reg[COMP_W-2:0], rem_ge};
    assign q_signed = neg_reg ? (COMP_W'(0) - qsh_next) : qsh_next;

    assign alpha_diff = ONE_Q16 - prod_reg;

    // Sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            div_idx_reg   <= '0;
            step_reg      <= '0;
            total_reg     <= '0;
            prod_reg      <= ONE_Q16;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NCOMP; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else
        begin
            // Result valid: set on finish, cleared once taken
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        idx_reg     <= '0;
                        div_idx_reg <= '0;
                        if (grp_full)
                        begin
                            // excess splat: flag only
                            ovf_reg   <= 1'b1;
                            state_reg <= last_in_group ? S_DLOAD : S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_ACC;
                        end
                    end
                end

                S_ACC:
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (idx_reg != '0)
                    begin
                        if (idx_reg <= IDX_W'(NCOMP))
                        begin
                            sums_reg[acc_idx] <= sums_reg[acc_idx] + mul_ext;
                        end
                        else
                        begin
                            prod_reg <= mul_reg[32:16];
                        end
                    end
                    if (idx_reg == IDX_W'(NCOMP + 1))
                    begin
                        total_reg <= total_reg + TOT_W'(alpha_reg);
                        cnt_reg   <= cnt_reg + CNT_W'(1);
                        state_reg <= last_reg ? S_DLOAD : S_IDLE;
                    end
                end

                S_DLOAD:
                begin
                    step_reg  <= '0;
                    state_reg <= S_DSTEP;
                end

                S_DSTEP:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(COMP_W - 1))
                    begin
                        if (div_idx_reg == CI_W'(NCOMP - 1))
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            div_idx_reg <= div_idx_reg + CI_W'(1);
                            state_reg   <= S_DLOAD;
                        end
                    end
                end

                S_FIN:
                begin
                    if (out_free)
                    begin
                        total_reg     <= '0;
                        prod_reg      <= ONE_Q16;
                        cnt_reg       <= '0;
                        ovf_reg       <= 1'b0;
                        for (int i = 0; i < NCOMP; i++)
                        begin
                            sums_reg[i] <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers: input hold, multiplier, divider, result
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            comp_reg[0] <= pos_x;
            comp_reg[1] <= pos_y;
            comp_reg[2] <= pos_z;
            comp_reg[3] <= color_r;
            comp_reg[4] <= color_g;
            comp_reg[5] <= color_b;
            comp_reg[6] <= size_x;
            comp_reg[7] <= size_y;
            comp_reg[8] <= size_z;
            alpha_reg   <= alpha;
            last_reg    <= last_in_group;
        end

        if (state_reg == S_ACC)
        begin
            mul_reg <= mul_next;
        end

        if (state_reg == S_DLOAD)
        begin
            rem_reg <= sum_mag[SUM_W-1:COMP_W];
            qsh_reg <= sum_mag[COMP_W-1:0];
            neg_reg <= sum_rd[SUM_W-1];
        end
        else if (state_reg == S_DSTEP)
        begin
            rem_reg <= rem_next;
            qsh_reg <= qsh_next;
            if (step_reg == STEP_W'(COMP_W - 1))
            begin
                quot_reg[div_idx_reg] <= q_signed;
            end
        end

        if (state_reg == S_FIN && out_free)
        begin
            for (int i = 0; i < NCOMP; i++)
            begin
                merged_reg[i] <= quot_reg[i];
            end
            merged_alpha_reg   <= alpha_diff[16:1];
            group_overflow_reg <= ovf_reg;
        end
    end

    // Output ports
    assign out_valid      = out_valid_reg;
    assign merged_x       = merged_reg[0];
    assign merged_y       = merged_reg[1];
    assign merged_z       = merged_reg[2];
    assign merged_r       = merged_reg[3];
    assign merged_g       = merged_reg[4];
    assign merged_b       = merged_reg[5];
    assign merged_sx      = merged_reg[6];
    assign merged_sy      = merged_reg[7];
    assign merged_sz      = merged_reg[8];
    assign merged_alpha   = merged_alpha_reg;
    assign group_overflow = group_overflow_reg;

    // Group count never passes the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_GROUP))
        else $error("group count beyond limit");

    // Partial remainder stays below the divisor through every step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DSTEP) |-> (rem_reg < div_d))
        else $error("divider remainder out of range");

    // Transparency product never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC) |=> (prod_reg <= ONE_Q16))
        else $error("transparency product above one");

    // A result only appears out of the finish state, which clears the group
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_FIN
                                  && total_reg == '0 && cnt_reg == '0))
        else $error("result without group clear");

    // A completed accumulate pass leaves a nonzero group count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC && idx_reg == IDX_W'(NCOMP + 1)) |=> (cnt_reg != '0))
        else $error("accumulate pass did not count splat");

endmodule

/* verif/opacity_weighted_splat_merge_tb.sv */
// Self-checking testbench for the opacity-weighted splat merge block.
module opacity_weighted_splat_merge_tb
    import owsm_pkg::*;
();

    localparam int GROUP_LIMIT   = MAX_GROUP_DEF;
    localparam int RANDOM_SPLATS = 900;
    localparam int DRAIN_CYCLES  = 400;        // longer than one group-end merge
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int IDLE_PCT      = 28;

    // One input splat: components in port order pos x,y,z, color r,g,b, size x,y,z
    typedef struct packed {
        logic [NCOMP-1:0][COMP_W-1:0] comp;
        logic [ALPHA_W-1:0]           alpha;
        logic                         last;
    } splat_t;

    // One merged splat
    typedef struct packed {
        logic [NCOMP-1:0][COMP_W-1:0] comp;
        logic [ALPHA_W-1:0]           alpha;
        logic                         ovf;
    } merged_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic signed [COMP_W-1:0]  pos_x = '0;
    logic signed [COMP_W-1:0]  pos_y = '0;
    logic signed [COMP_W-1:0]  pos_z = '0;
    logic signed [COMP_W-1:0]  color_r = '0;
    logic signed [COMP_W-1:0]  color_g = '0;
    logic signed [COMP_W-1:0]  color_b = '0;
    logic signed [COMP_W-1:0]  size_x = '0;
    logic signed [COMP_W-1:0]  size_y = '0;
    logic signed [COMP_W-1:0]  size_z = '0;
    logic        [ALPHA_W-1:0] alpha = '0;
    logic                      last_in_group = 1'b0;

    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [COMP_W-1:0]  merged_x;
    logic signed [COMP_W-1:0]  merged_y;
    logic signed [COMP_W-1:0]  merged_z;
    logic signed [COMP_W-1:0]  merged_r;
    logic signed [COMP_W-1:0]  merged_g;
    logic signed [COMP_W-1:0]  merged_b;
    logic signed [COMP_W-1:0]  merged_sx;
    logic signed [COMP_W-1:0]  merged_sy;
    logic signed [COMP_W-1:0]  merged_sz;
    logic        [ALPHA_W-1:0] merged_alpha;
    logic                      group_overflow;

    // Predicted group state
    longint  wsum [NCOMP];
    longint  wtotal;
    longint  tprod;                 // Q1.16 transparency product
    int      held;                  // splats accumulated in the open group
    bit      dropped_any;           // a splat beyond the limit arrived

    merged_t merged_expected [$];
    int      mismatch_count = 0;
    int      merged_seen = 0;
    int      cycle_count = 0;
    bit      steady = 1'b0;         // no idling on either side while set

    opacity_weighted_splat_merge #(
        .MAX_GROUP(GROUP_LIMIT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .pos_z(pos_z),
        .color_r(color_r),
        .color_g(color_g),
        .color_b(color_b),
        .size_x(size_x),
        .size_y(size_y),
        .size_z(size_z),
        .alpha(alpha),
        .last_in_group(last_in_group),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .merged_x(merged_x),
        .merged_y(merged_y),
        .merged_z(merged_z),
        .merged_r(merged_r),
        .merged_g(merged_g),
        .merged_b(merged_b),
        .merged_sx(merged_sx),
        .merged_sy(merged_sy),
        .merged_sz(merged_sz),
        .merged_alpha(merged_alpha),
        .group_overflow(group_overflow)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Open a new group in the predictor
    function automatic void clear_merge_state();
        for (int k = 0; k < NCOMP; k++)
            wsum[k] = 0;
        wtotal      = 0;
        tprod       = longint'(ONE_Q16);
        held        = 0;
        dropped_any = 1'b0;
    endfunction

    // Accumulate one accepted splat; on the group's last splat queue the merged result
    function automatic void merge_predict(input splat_t s);
        merged_t m;
        longint  clamped;
        longint  q;
        if (held >= GROUP_LIMIT)
            dropped_any = 1'b1;
        else
        begin
            clamped = (s.alpha > ONE_Q15) ? longint'(ONE_Q15) : longint'(s.alpha);
            for (int k = 0; k < NCOMP; k++)
                wsum[k] += longint'($signed(s.comp[k])) * longint'(s.alpha);
            wtotal += longint'(s.alpha);
            tprod = (tprod * (longint'(ONE_Q16) - 2 * clamped)) >> 16;
            held++;
        end
        if (s.last)
        begin
            // zero total weight divides by one, and all sums are zero then
            for (int k = 0; k < NCOMP; k++)
            begin
                q = (wtotal != 0) ? wsum[k] / wtotal : 0;
                m.comp[k] = q[COMP_W-1:0];
            end
            m.alpha = ALPHA_W'((longint'(ONE_Q16) - tprod) >> 1);
            m.ovf   = dropped_any;
            merged_expected.push_back(m);
            clear_merge_state();
        end
    endfunction

    // Components lean on the extremes, zero and values within +-1.0, the rest fully random
    function automatic logic [COMP_W-1:0] draw_component();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return COMP_W'($urandom_range(131072) - 65536);
            default: return $urandom;
        endcase
    endfunction

    // Opacity: zero, exactly one, above one, tiny, and anywhere
    function automatic logic [ALPHA_W-1:0] draw_opacity();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ONE_Q15;
            2:       return 16'hffff;
            3:       return ALPHA_W'($urandom_range(65535, 32769));
            4:       return ALPHA_W'($urandom_range(16, 1));
            default: return ALPHA_W'($urandom_range(65535));
        endcase
    endfunction

    function automatic splat_t random_splat(input logic [ALPHA_W-1:0] a, input logic last);
        splat_t s;
        for (int k = 0; k < NCOMP; k++)
            s.comp[k] = draw_component();
        s.alpha = a;
        s.last  = last;
        return s;
    endfunction

    function automatic splat_t uniform_splat(input logic [COMP_W-1:0] v,
                                             input logic [ALPHA_W-1:0] a, input logic last);
        splat_t s;
        for (int k = 0; k < NCOMP; k++)
            s.comp[k] = v;
        s.alpha = a;
        s.last  = last;
        return s;
    endfunction

    // Send one splat transaction, idling at random first, then predict it
    task automatic send_splat(input splat_t s);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        {size_z, size_y, size_x, color_b, color_g, color_r, pos_z, pos_y, pos_x} <= s.comp;
        alpha         <= s.alpha;
        last_in_group <= s.last;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        merge_predict(s);
    endtask

    task automatic report_mismatch(input string msg);
        $display("merge mismatch at result %0d: %s", merged_seen, msg);
        mismatch_count++;
    endtask

    // Compare one merged transaction against the oldest prediction
    task automatic check_merged();
        merged_t got;
        merged_t want;
        got.comp  = {merged_sz, merged_sy, merged_sx, merged_b, merged_g, merged_r,
                     merged_z, merged_y, merged_x};
        got.alpha = merged_alpha;
        got.ovf   = group_overflow;
        merged_seen++;
        if (merged_expected.size() == 0)
        begin
            report_mismatch("merged splat with no group pending");
            return;
        end
        want = merged_expected.pop_front();
        for (int k = 0; k < NCOMP; k++)
            if (got.comp[k] !== want.comp[k])
                report_mismatch($sformatf("component %0d got %h want %h",
                                          k, got.comp[k], want.comp[k]));
        if (got.alpha !== want.alpha)
            report_mismatch($sformatf("merged_alpha got %h want %h", got.alpha, want.alpha));
        if (got.ovf !== want.ovf)
            report_mismatch($sformatf("group_overflow got %b want %b", got.ovf, want.ovf));
    endtask

    // Output side: check accepted results, stall at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_merged();
        out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    // Single-splat groups at the field extremes
    task automatic test_extreme_singles();
        send_splat(uniform_splat(32'h7fff_ffff, ONE_Q15, 1'b1));
        send_splat(uniform_splat(32'h8000_0000, 16'h0001, 1'b1));
        send_splat(uniform_splat(32'h8000_0000, 16'hffff, 1'b1));
        send_splat(uniform_splat(32'h0000_0000, 16'h7fff, 1'b1));
        send_splat(random_splat(16'h0001, 1'b1));
    endtask

    // Groups mixing opposite extremes
    task automatic test_mixed_group();
        send_splat(uniform_splat(32'h7fff_ffff, 16'hffff, 1'b0));
        send_splat(uniform_splat(32'h8000_0000, 16'hffff, 1'b0));
        send_splat(uniform_splat(32'h0000_0001, 16'h0001, 1'b1));
        send_splat(random_splat(16'hffff, 1'b0));
        send_splat(random_splat(ONE_Q15, 1'b1));
    endtask

    // All-zero opacity: division by one, merged splat all zero
    task automatic test_zero_weight();
        send_splat(random_splat('0, 1'b0));
        send_splat(random_splat('0, 1'b0));
        send_splat(random_splat('0, 1'b1));
        send_splat(random_splat('0, 1'b1));
    endtask

    // Opacity above one weighs raw but clamps in the transparency
    task automatic test_opacity_over_one();
        send_splat(uniform_splat(32'h0001_0000, 16'h8001, 1'b0));
        send_splat(uniform_splat(32'hffff_0000, 16'hffff, 1'b1));
        send_splat(uniform_splat(32'h1234_5678, 16'h7fff, 1'b0));
        send_splat(random_splat(16'h4000, 1'b1));
    endtask

    // A group right at the limit, then one two splats past it whose last two splats are dropped
    task automatic test_group_limit();
        for (int i = 0; i < GROUP_LIMIT; i++)
            send_splat(random_splat(draw_opacity(), i == GROUP_LIMIT - 1));
        for (int i = 0; i < GROUP_LIMIT + 2; i++)
            send_splat(random_splat(draw_opacity(), i == GROUP_LIMIT + 1));
    endtask

    // Random groups: mostly short, a few zero-weight, a few near or past the limit
    task automatic test_random_groups();
        int  sent;
        int  glen;
        int  pick;
        bit  zero_grp;
        sent = 0;
        while (sent < RANDOM_SPLATS)
        begin
            pick = $urandom_range(39);
            if (pick == 0)
                glen = $urandom_range(GROUP_LIMIT + 6, GROUP_LIMIT - 2);
            else if (pick < 8)
                glen = 1;
            else
                glen = $urandom_range(8, 2);
            zero_grp = ($urandom_range(14) == 0);
            for (int i = 0; i < glen; i++)
            begin
                steady = (sent >= 400 && sent < 560);
                send_splat(random_splat(zero_grp ? '0 : draw_opacity(), i == glen - 1));
                sent++;
            end
        end
        steady = 1'b0;
    endtask

    // Sequence
    initial
    begin
        clear_merge_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extreme_singles();
        test_mixed_group();
        test_zero_weight();
        test_opacity_over_one();
        test_group_limit();
        test_random_groups();
        in_valid <= 1'b0;
        while (merged_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/owsm_pkg.sv
hw/rtl/opacity_weighted_splat_merge.sv
verif/opacity_weighted_splat_merge_tb.sv
